// ===== design/assert_macros.svh =====
// assertion helpers shared by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is low
`define SBMR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define SBMR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/sbmr_pkg.sv =====
`timescale 1ns / 1ps
package sbmr_pkg;

    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_ADD   = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    localparam int PIX_W       = 16;
    localparam int COEF_W      = 32;
    localparam int VEC_W       = 18;
    localparam int PROD_W      = COEF_W + VEC_W;
    localparam int H_W         = 52;
    localparam int WORLD_W     = 32;
    localparam int MAT_REG_W   = 64;
    localparam int NUM_MAT     = 8;
    localparam int CFG_IDX_W   = 4;
    localparam int FRAC_W      = 16;

    localparam logic signed [PIX_W:0] ROW_WIN = 17'sd48;
    localparam logic signed [VEC_W-1:0] ONE_Q4 = 18'sd16;

    localparam logic [WORLD_W-1:0] LIM_POS = 32'h7FFF_FFFF;
    localparam logic [WORLD_W-1:0] LIM_NEG = 32'h8000_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MAC,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_CHECK,
        DIV_LOOP,
        DIV_DONE
    } t_div_state;

    typedef struct packed {
        logic               done;
        logic [WORLD_W-1:0] q;
    } t_div_res;

endpackage

// ===== design/sbmr_in_if.sv =====
`timescale 1ns / 1ps
interface sbmr_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] point_x;
    logic [15:0] point_y;

    modport source (output valid, kind, point_x, point_y, input ready);
    modport sink (input valid, kind, point_x, point_y, output ready);
endinterface

// ===== design/sbmr_out_if.sv =====
`timescale 1ns / 1ps
interface sbmr_out_if;
    logic               valid;
    logic               ready;
    logic [15:0]        left_x;
    logic [15:0]        left_y;
    logic [15:0]        right_x;
    logic [15:0]        right_y;
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;
    logic               divide_fault;

    modport source (output valid, left_x, left_y, right_x, right_y, world_x, world_y,
                    world_z, divide_fault, input ready);
    modport sink (input valid, left_x, left_y, right_x, right_y, world_x, world_y,
                  world_z, divide_fault, output ready);
endinterface

// ===== design/sbmr_store.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sbmr_store #(
    parameter int DEPTH = 64,
    parameter int IW    = 6,
    parameter int CW    = 7
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_clear,
    input  logic                         i_add,
    input  logic [sbmr_pkg::PIX_W-1:0]   i_col,
    input  logic [sbmr_pkg::PIX_W-1:0]   i_row,
    input  logic [IW-1:0]                i_rd_addr,
    output logic [sbmr_pkg::PIX_W-1:0]   o_rd_col,
    output logic [sbmr_pkg::PIX_W-1:0]   o_rd_row,
    output logic [CW-1:0]                o_count
);

    logic [sbmr_pkg::PIX_W-1:0] r_mem_col [DEPTH];
    logic [sbmr_pkg::PIX_W-1:0] r_mem_row [DEPTH];
    logic [CW-1:0]              r_count;
    logic                       w_room;

    assign w_room  = r_count < CW'(DEPTH);
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_clear) begin
            r_count <= '0;
        end else if (i_add && w_room) begin
            r_count <= r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_add && w_room) begin
            r_mem_col[r_count[IW-1:0]] <= i_col;
            r_mem_row[r_count[IW-1:0]] <= i_row;
        end
        o_rd_col <= r_mem_col[i_rd_addr];
        o_rd_row <= r_mem_row[i_rd_addr];
    end

    `SBMR_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(DEPTH), "store count overflow")
    `SBMR_ASSERT(a_clear_empties, i_clk, i_rst_n, i_clear |=> r_count == '0, "clear missed")

endmodule

// ===== design/sbmr_mac.sv =====
`timescale 1ns / 1ps
module sbmr_mac (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_start,
    input  logic [sbmr_pkg::MAT_REG_W-1:0]           i_mat [sbmr_pkg::NUM_MAT],
    input  logic [sbmr_pkg::PIX_W-1:0]               i_px,
    input  logic [sbmr_pkg::PIX_W-1:0]               i_py,
    input  logic [sbmr_pkg::PIX_W-1:0]               i_rx,
    output logic                                     o_done,
    output logic signed [sbmr_pkg::H_W-1:0]          o_h [4]
);

    logic                                   r_busy;
    logic [4:0]                             r_k;
    logic signed [sbmr_pkg::PROD_W-1:0]     r_prod;
    logic [3:0]                             r_pk;
    logic                                   r_pv;
    logic [1:0]                             w_row;
    logic [1:0]                             w_col;
    logic [sbmr_pkg::MAT_REG_W-1:0]         w_reg;
    logic signed [sbmr_pkg::COEF_W-1:0]     w_coef;
    logic signed [sbmr_pkg::VEC_W-1:0]      w_vec;
    logic signed [sbmr_pkg::PROD_W-1:0]     n_prod;

    assign w_row = r_k[3:2];
    assign w_col = r_k[1:0];

    always_comb begin
        w_reg  = i_mat[{w_row, w_col[1]}];
        w_coef = w_col[0] ? w_reg[63:32] : w_reg[31:0];
        case (w_col)
            2'd0:    w_vec = signed'({2'b00, i_px});
            2'd1:    w_vec = signed'({2'b00, i_py});
            2'd2:    w_vec = signed'({2'b00, i_rx}) - signed'({2'b00, i_px});
            default: w_vec = sbmr_pkg::ONE_Q4;
        endcase
        n_prod = w_coef * w_vec;
    end

    assign o_done = r_busy && (r_k == 5'd17);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k    <= '0;
            r_pv   <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_k    <= '0;
            r_pv   <= 1'b0;
        end else if (r_busy) begin
            r_pv <= r_k < 5'd16;
            if (r_k == 5'd17) begin
                r_busy <= 1'b0;
            end else begin
                r_k <= r_k + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_pk   <= r_k[3:0];
        if (r_busy && r_pv) begin
            if (r_pk[1:0] == 2'd0) begin
                o_h[r_pk[3:2]] <= sbmr_pkg::H_W'(r_prod);
            end else begin
                o_h[r_pk[3:2]] <= o_h[r_pk[3:2]] + sbmr_pkg::H_W'(r_prod);
            end
        end
    end

endmodule

// ===== design/sbmr_div.sv =====
`timescale 1ns / 1ps
module sbmr_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [sbmr_pkg::H_W-1:0]   i_num,
    input  logic signed [sbmr_pkg::H_W-1:0]   i_den,
    input  logic                              i_neg,
    output sbmr_pkg::t_div_res                o_res
);

    localparam int HW = sbmr_pkg::H_W;
    localparam int QW = sbmr_pkg::WORLD_W;
    localparam int FW = sbmr_pkg::FRAC_W;

    sbmr_pkg::t_div_state r_state, n_state;

    logic [HW-1:0] r_n, r_d, r_rem;
    logic [QW-1:0] r_low, r_q;
    logic          r_neg, r_sat;
    logic [4:0]    r_cnt;
    logic [HW:0]   w_sh;
    logic          w_ge;
    logic [QW-1:0] w_lim, w_mag;

    assign w_sh  = {r_rem, r_low[QW-1]};
    assign w_ge  = w_sh >= {1'b0, r_d};
    assign w_lim = r_neg ? sbmr_pkg::LIM_NEG : sbmr_pkg::LIM_POS;

    always_comb begin
        n_state = r_state;
        case (r_state)
            sbmr_pkg::DIV_IDLE:  if (i_start) n_state = sbmr_pkg::DIV_CHECK;
            sbmr_pkg::DIV_CHECK: n_state = sbmr_pkg::DIV_LOOP;
            sbmr_pkg::DIV_LOOP:  if (r_sat || r_cnt == 5'd31) n_state = sbmr_pkg::DIV_DONE;
            sbmr_pkg::DIV_DONE:  n_state = i_start ? sbmr_pkg::DIV_CHECK : sbmr_pkg::DIV_IDLE;
            default:             n_state = sbmr_pkg::DIV_IDLE;
        endcase
        w_mag = (r_sat || r_q > w_lim) ? w_lim : r_q;
        o_res.done = r_state == sbmr_pkg::DIV_DONE;
        o_res.q    = r_neg ? (QW'(0) - w_mag) : w_mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sbmr_pkg::DIV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            sbmr_pkg::DIV_IDLE, sbmr_pkg::DIV_DONE: begin
                r_n   <= i_num[HW-1] ? HW'(-i_num) : HW'(i_num);
                r_d   <= i_den[HW-1] ? HW'(-i_den) : HW'(i_den);
                r_neg <= i_neg ^ i_num[HW-1] ^ i_den[HW-1];
            end
            sbmr_pkg::DIV_CHECK: begin
                r_sat <= {FW'(0), r_n} >= {r_d, FW'(0)};
                r_rem <= r_n >> FW;
                r_low <= {r_n[FW-1:0], FW'(0)};
                r_q   <= '0;
                r_cnt <= '0;
            end
            sbmr_pkg::DIV_LOOP: begin
                r_rem <= w_ge ? HW'(w_sh - {1'b0, r_d}) : w_sh[HW-1:0];
                r_q   <= {r_q[QW-2:0], w_ge};
                r_low <= {r_low[QW-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== design/stereo_blob_match_reproject_top.sv =====
`timescale 1ns / 1ps
// frame clear and right blob add: accepted in the idle state, ready stays high
// left query: scan of the N stored blobs, N = stored blobs, then multiply-accumulate
// then three divisions, after which the result is made valid on the output
// saturated division stops after its first loop step, zero w skips divisions, unmatched query ends after scan
// a waiting result holds the block in its output state until taken
// synchronous active-low reset clears matrix registers, store count and control
`include "assert_macros.svh"
module stereo_blob_match_reproject_top #(
    parameter int MAX_RIGHT_BLOBS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [sbmr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [sbmr_pkg::MAT_REG_W-1:0]      i_cfg_data,
    sbmr_in_if.sink                             i_req,
    sbmr_out_if.source                          o_res
);

    localparam int IW = (MAX_RIGHT_BLOBS > 1) ? $clog2(MAX_RIGHT_BLOBS) : 1;
    localparam int CW = $clog2(MAX_RIGHT_BLOBS + 1);
    localparam int PW = sbmr_pkg::PIX_W;
    localparam int HW = sbmr_pkg::H_W;
    localparam int QW = sbmr_pkg::WORLD_W;

    sbmr_pkg::t_state r_state, n_state;

    logic [sbmr_pkg::MAT_REG_W-1:0] r_mat [sbmr_pkg::NUM_MAT];
    logic [PW-1:0] r_px, r_py, r_best_col, r_best_row, w_rd_col, w_rd_row;
    logic [CW-1:0] r_idx, w_count;
    logic          r_pend, r_found, w_issue, w_scan_done, w_in_win, w_best_win;
    logic [1:0]    r_dsel, w_dnum_sel;
    logic [QW-1:0] r_wx, r_wy, r_wz;
    logic          r_fault;
    logic          r_ov;
    logic          w_acc, w_clear, w_add, w_query;
    logic          w_mac_start, w_mac_done, w_div_start, w_h3_zero;
    logic signed [HW-1:0] w_h [4];
    logic signed [PW:0]   w_dy, w_bdy;
    sbmr_pkg::t_div_res   w_div;

    assign i_req.ready = r_state == sbmr_pkg::ST_IDLE;
    assign w_acc   = i_req.valid && i_req.ready;
    assign w_clear = w_acc && i_req.kind == sbmr_pkg::KIND_CLEAR;
    assign w_add   = w_acc && i_req.kind == sbmr_pkg::KIND_ADD;
    assign w_query = w_acc && i_req.kind == sbmr_pkg::KIND_QUERY;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < sbmr_pkg::NUM_MAT; k++) begin
                r_mat[k] <= '0;
            end
        end else if (i_cfg_we && i_cfg_idx < sbmr_pkg::CFG_IDX_W'(sbmr_pkg::NUM_MAT)) begin
            r_mat[i_cfg_idx[2:0]] <= i_cfg_data;
        end
    end

    sbmr_store #(.DEPTH(MAX_RIGHT_BLOBS), .IW(IW), .CW(CW)) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (w_clear),
        .i_add     (w_add),
        .i_col     (i_req.point_x),
        .i_row     (i_req.point_y),
        .i_rd_addr (r_idx[IW-1:0]),
        .o_rd_col  (w_rd_col),
        .o_rd_row  (w_rd_row),
        .o_count   (w_count)
    );

    // row window test on the entry read last cycle
    assign w_issue     = r_idx < w_count;
    assign w_scan_done = !w_issue && !r_pend;
    assign w_dy        = signed'({1'b0, r_py}) - signed'({1'b0, w_rd_row});
    assign w_in_win    = w_dy < sbmr_pkg::ROW_WIN && w_dy > -sbmr_pkg::ROW_WIN;
    assign w_bdy       = signed'({1'b0, r_py}) - signed'({1'b0, r_best_row});
    assign w_best_win  = w_bdy < sbmr_pkg::ROW_WIN && w_bdy > -sbmr_pkg::ROW_WIN;

    sbmr_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mac_start),
        .i_mat   (r_mat),
        .i_px    (r_px),
        .i_py    (r_py),
        .i_rx    (r_best_col),
        .o_done  (w_mac_done),
        .o_h     (w_h)
    );

    assign w_h3_zero  = w_h[3] == '0;
    assign w_dnum_sel = (r_state == sbmr_pkg::ST_MAC) ? 2'd0 : r_dsel + 2'd1;

    sbmr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_h[w_dnum_sel]),
        .i_den   (w_h[3]),
        .i_neg   (w_dnum_sel == 2'd0),
        .o_res   (w_div)
    );

    always_comb begin
        n_state     = r_state;
        w_mac_start = 1'b0;
        w_div_start = 1'b0;
        case (r_state)
            sbmr_pkg::ST_IDLE: begin
                if (w_query) n_state = sbmr_pkg::ST_SCAN;
            end
            sbmr_pkg::ST_SCAN: begin
                if (w_scan_done) begin
                    if (r_found) begin
                        w_mac_start = 1'b1;
                        n_state     = sbmr_pkg::ST_MAC;
                    end else begin
                        n_state = sbmr_pkg::ST_IDLE;
                    end
                end
            end
            sbmr_pkg::ST_MAC: begin
                if (w_mac_done) begin
                    if (w_h3_zero) begin
                        n_state = sbmr_pkg::ST_OUT;
                    end else begin
                        w_div_start = 1'b1;
                        n_state     = sbmr_pkg::ST_DIV;
                    end
                end
            end
            sbmr_pkg::ST_DIV: begin
                if (w_div.done) begin
                    if (r_dsel == 2'd2) begin
                        n_state = sbmr_pkg::ST_OUT;
                    end else begin
                        w_div_start = 1'b1;
                    end
                end
            end
            sbmr_pkg::ST_OUT: begin
                if (!r_ov || o_res.ready) n_state = sbmr_pkg::ST_IDLE;
            end
            default: n_state = sbmr_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sbmr_pkg::ST_IDLE;
            r_ov    <= 1'b0;
            r_pend  <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == sbmr_pkg::ST_OUT && n_state == sbmr_pkg::ST_IDLE) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
            if (w_query) begin
                r_pend  <= 1'b0;
                r_found <= 1'b0;
            end else if (r_state == sbmr_pkg::ST_SCAN) begin
                r_pend <= w_issue;
                if (r_pend && w_in_win && (!r_found || w_rd_col > r_best_col)) begin
                    r_found <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_query) begin
            r_px  <= i_req.point_x;
            r_py  <= i_req.point_y;
            r_idx <= '0;
        end
        if (r_state == sbmr_pkg::ST_SCAN) begin
            if (w_issue) r_idx <= r_idx + 1'b1;
            if (r_pend && w_in_win && (!r_found || w_rd_col > r_best_col)) begin
                r_best_col <= w_rd_col;
                r_best_row <= w_rd_row;
            end
        end
        if (r_state == sbmr_pkg::ST_MAC && w_mac_done) begin
            r_dsel  <= 2'd0;
            r_fault <= w_h3_zero;
            r_wx    <= '0;
            r_wy    <= '0;
            r_wz    <= '0;
        end
        if (r_state == sbmr_pkg::ST_DIV && w_div.done) begin
            case (r_dsel)
                2'd0:    r_wx <= w_div.q;
                2'd1:    r_wy <= w_div.q;
                default: r_wz <= w_div.q;
            endcase
            r_dsel <= r_dsel + 2'd1;
        end
        if (r_state == sbmr_pkg::ST_OUT && n_state == sbmr_pkg::ST_IDLE) begin
            o_res.left_x       <= r_px;
            o_res.left_y       <= r_py;
            o_res.right_x      <= r_best_col;
            o_res.right_y      <= r_best_row;
            o_res.world_x      <= r_wx;
            o_res.world_y      <= r_wy;
            o_res.world_z      <= r_wz;
            o_res.divide_fault <= r_fault;
        end
    end

    assign o_res.valid = r_ov;

    `SBMR_ASSERT(a_fault_zero, i_clk, i_rst_n, (o_res.valid && o_res.divide_fault) |-> (o_res.world_x == '0 && o_res.world_y == '0 && o_res.world_z == '0), "fault with nonzero world")
    `SBMR_ASSERT(a_best_in_window, i_clk, i_rst_n, (r_found && r_state == sbmr_pkg::ST_MAC) |-> w_best_win, "match outside row window")
    `SBMR_ASSERT(a_mac_needs_match, i_clk, i_rst_n, w_mac_start |-> r_found, "reprojection without match")

endmodule

// ===== sim/stereo_blob_match_reproject_top_tb.sv =====
`timescale 1ns / 1ps
module stereo_blob_match_reproject_top_tb;

    localparam int STORE_DEPTH = 64;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int RANDOM_ITEMS = 1300;

    typedef struct {
        logic [15:0]        lx;
        logic [15:0]        ly;
        logic [15:0]        rx;
        logic [15:0]        ry;
        logic signed [31:0] wx;
        logic signed [31:0] wy;
        logic signed [31:0] wz;
        logic               fault;
    } t_match;

    typedef struct {
        logic [1:0]  kind;
        logic [15:0] px;
        logic [15:0] py;
        logic        has_fixed;
        t_match      fixed;
    } t_row;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [sbmr_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [sbmr_pkg::MAT_REG_W-1:0] i_cfg_data;

    sbmr_in_if  req_if ();
    sbmr_out_if res_if ();

    stereo_blob_match_reproject_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if.sink),
        .o_res      (res_if.source)
    );

    logic [sbmr_pkg::MAT_REG_W-1:0] mat_shadow [sbmr_pkg::NUM_MAT];
    logic [15:0]          col_shadow [STORE_DEPTH];
    logic [15:0]          row_shadow [STORE_DEPTH];
    int                   blob_count;

    t_match pending_matches [$];
    t_row   directed_rows [$];
    int     mismatch_count;
    int     match_count;
    int     fault_count;
    int     query_count;
    int     cycle_count;
    int     send_idle_pct;
    int     recv_idle_pct;
    int     hold_off;
    bit     stimulus_done;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic signed [63:0] coef_of(int r, int c);
        logic [63:0] reg_val;
        reg_val = mat_shadow[r * 2 + c / 2];
        return (c % 2) ? 64'(signed'(reg_val[63:32])) : 64'(signed'(reg_val[31:0]));
    endfunction

    function automatic logic [31:0] quot_q16(logic signed [63:0] num,
                                            logic signed [63:0] den, bit neg);
        logic [63:0] n;
        logic [63:0] d;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] lim;
        bit          sat;
        n = num < 0 ? -num : num;
        d = den < 0 ? -den : den;
        if ((num < 0) != (den < 0)) neg = !neg;
        q = n / d;
        r = n % d;
        sat = q >= 64'h10000;
        if (!sat) begin
            for (int i = 0; i < 16; i++) begin
                r = r << 1;
                q = q << 1;
                if (r >= d) begin
                    r = r - d;
                    q[0] = 1'b1;
                end
            end
        end
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        if (sat || q > lim) q = lim;
        return neg ? 32'(-q) : 32'(q);
    endfunction

    // updates the right store and returns 1 when a query finds a match
    function automatic bit reproject_blob(logic [1:0] kind, logic [15:0] px,
                                          logic [15:0] py, output t_match m);
        int                 best;
        bit                 found;
        int                 dy;
        logic signed [63:0] vec [4];
        logic signed [63:0] h [4];
        best = 0;
        found = 0;
        m = '{default: '0};
        if (kind == sbmr_pkg::KIND_CLEAR) begin
            blob_count = 0;
            return 0;
        end
        if (kind == sbmr_pkg::KIND_ADD) begin
            if (blob_count < STORE_DEPTH) begin
                col_shadow[blob_count] = px;
                row_shadow[blob_count] = py;
                blob_count++;
            end
            return 0;
        end
        if (kind != sbmr_pkg::KIND_QUERY) return 0;
        for (int i = 0; i < blob_count; i++) begin
            dy = int'(py) - int'(row_shadow[i]);
            if (dy < 48 && dy > -48 && (!found || col_shadow[i] > col_shadow[best])) begin
                best = i;
                found = 1;
            end
        end
        if (!found) return 0;
        vec[0] = px;
        vec[1] = py;
        vec[2] = 64'(col_shadow[best]) - 64'(px);
        vec[3] = 16;
        for (int r = 0; r < 4; r++) begin
            h[r] = 0;
            for (int c = 0; c < 4; c++) h[r] += coef_of(r, c) * vec[c];
        end
        m.lx = px;
        m.ly = py;
        m.rx = col_shadow[best];
        m.ry = row_shadow[best];
        if (h[3] == 0) begin
            m.fault = 1'b1;
        end else begin
            m.wx = quot_q16(h[0], h[3], 1'b1);
            m.wy = quot_q16(h[1], h[3], 1'b0);
            m.wz = quot_q16(h[2], h[3], 1'b0);
        end
        return 1;
    endfunction

    task automatic write_matrix(int idx, logic [63:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx[sbmr_pkg::CFG_IDX_W-1:0];
        i_cfg_data <= val;
        mat_shadow[idx] = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // leaves valid high after the accepting edge; the next request drops it or replaces its data, a drain drops it
    task automatic send_request(logic [1:0] kind, logic [15:0] px, logic [15:0] py,
                                bit has_fixed, t_match fixed);
        t_match m;
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.kind    <= kind;
        req_if.point_x <= px;
        req_if.point_y <= py;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        if (kind == sbmr_pkg::KIND_QUERY) query_count++;
        if (reproject_blob(kind, px, py, m)) begin
            pending_matches.push_back(has_fixed ? fixed : m);
        end
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (pending_matches.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            res_if.ready <= 1'b0;
            hold_off <= hold_off - 1;
        end else begin
            res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_match want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_matches.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected result lx=%h", res_if.left_x);
            end else begin
                want = pending_matches.pop_front();
                match_count++;
                if (res_if.divide_fault) fault_count++;
                if (res_if.left_x !== want.lx || res_if.left_y !== want.ly ||
                    res_if.right_x !== want.rx || res_if.right_y !== want.ry ||
                    res_if.world_x !== want.wx || res_if.world_y !== want.wy ||
                    res_if.world_z !== want.wz || res_if.divide_fault !== want.fault) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch exp l=%h,%h r=%h,%h w=%h,%h,%h f=%b",
                                 want.lx, want.ly, want.rx, want.ry,
                                 want.wx, want.wy, want.wz, want.fault);
                        $display("         got l=%h,%h r=%h,%h w=%h,%h,%h f=%b",
                                 res_if.left_x, res_if.left_y, res_if.right_x,
                                 res_if.right_y, res_if.world_x, res_if.world_y,
                                 res_if.world_z, res_if.divide_fault);
                    end
                end
            end
        end
    end

    function automatic t_row make_row(logic [1:0] kind, logic [15:0] px, logic [15:0] py);
        t_row row;
        row.kind = kind;
        row.px = px;
        row.py = py;
        row.has_fixed = 0;
        row.fixed = '{default: '0};
        return row;
    endfunction

    task automatic random_matrix(bit extreme);
        logic [63:0] val;
        for (int i = 0; i < sbmr_pkg::NUM_MAT; i++) begin
            val = {$urandom, $urandom};
            if (extreme) begin
                val = {($urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF),
                       ($urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF)};
            end else if ($urandom_range(3) != 0) begin
                val = {32'($signed($urandom_range(0, 2 ** 20)) - 2 ** 19),
                       32'($signed($urandom_range(0, 2 ** 20)) - 2 ** 19)};
            end
            // each w row register sometimes zeroed to trigger the divide fault
            if (i >= 6 && $urandom_range(7) == 0) val = '0;
            write_matrix(i, val);
        end
    endtask

    task automatic run_frames(int items);
        int          sent;
        int          adds;
        logic [15:0] base_y;
        logic [15:0] px;
        logic [15:0] py;
        logic [1:0]  kind;
        sent = 0;
        while (sent < items) begin
            if ($urandom_range(9) == 0) begin
                kind = 2'($urandom_range(3));
                send_request(kind, 16'($urandom), 16'($urandom), 0, '{default: '0});
                if (kind != 2'd3) sent++;
                continue;
            end
            send_request(sbmr_pkg::KIND_CLEAR, 16'($urandom), 16'($urandom), 0,
                         '{default: '0});
            sent++;
            base_y = 16'($urandom);
            adds = ($urandom_range(15) == 0) ? 70 : $urandom_range(1, 8);
            for (int i = 0; i < adds; i++) begin
                px = 16'($urandom);
                py = base_y + 16'($urandom_range(0, 120)) - 16'd60;
                send_request(sbmr_pkg::KIND_ADD, px, py, 0, '{default: '0});
                sent++;
            end
            for (int i = 0; i < $urandom_range(1, 6); i++) begin
                px = 16'($urandom);
                py = base_y + 16'($urandom_range(0, 160)) - 16'd80;
                send_request(sbmr_pkg::KIND_QUERY, px, py, 0, '{default: '0});
                sent++;
            end
        end
    endtask

    initial begin
        t_row row;
        t_match m;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        req_if.valid = 1'b0;
        req_if.kind = sbmr_pkg::KIND_CLEAR;
        req_if.point_x = '0;
        req_if.point_y = '0;
        res_if.ready = 1'b0;
        cycle_count = 0;
        mismatch_count = 0;
        match_count = 0;
        fault_count = 0;
        query_count = 0;
        hold_off = 0;
        blob_count = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stimulus_done = 0;
        for (int i = 0; i < sbmr_pkg::NUM_MAT; i++) mat_shadow[i] = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // all-zero matrix after reset: every match faults with zero world
        row = make_row(sbmr_pkg::KIND_ADD, 16'hFFFF, 16'h0000);
        directed_rows.push_back(row);
        row = make_row(sbmr_pkg::KIND_QUERY, 16'h0000, 16'h002F);
        row.has_fixed = 1;
        row.fixed = '{lx: 16'h0000, ly: 16'h002F, rx: 16'hFFFF, ry: 16'h0000,
                      wx: 0, wy: 0, wz: 0, fault: 1'b1};
        directed_rows.push_back(row);
        directed_rows.push_back(make_row(sbmr_pkg::KIND_QUERY, 16'h1234, 16'h0030));
        directed_rows.push_back(make_row(2'd3, 16'hFFFF, 16'hFFFF));
        directed_rows.push_back(make_row(sbmr_pkg::KIND_ADD, 16'h0100, 16'hFFFF));
        directed_rows.push_back(make_row(sbmr_pkg::KIND_ADD, 16'h0200, 16'hFFD1));
        directed_rows.push_back(make_row(sbmr_pkg::KIND_ADD, 16'h0200, 16'hFFE0));
        directed_rows.push_back(make_row(sbmr_pkg::KIND_QUERY, 16'hFFFF, 16'hFFFF));
        directed_rows.push_back(make_row(sbmr_pkg::KIND_QUERY, 16'h0000, 16'h0000));
        directed_rows.push_back(make_row(sbmr_pkg::KIND_CLEAR, 16'h0000, 16'h0000));
        directed_rows.push_back(make_row(sbmr_pkg::KIND_QUERY, 16'h0000, 16'h0000));
        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].kind, directed_rows[i].px, directed_rows[i].py,
                         directed_rows[i].has_fixed, directed_rows[i].fixed);
        end
        wait_drained();

        // identity-like matrix, then extremes, with a full store
        write_matrix(0, {32'h0000_0000, 32'h0001_0000});
        write_matrix(1, {32'h0000_0000, 32'h0000_0000});
        write_matrix(2, {32'h0001_0000, 32'h0000_0000});
        write_matrix(3, {32'h0000_0000, 32'h0000_0000});
        write_matrix(4, {32'h0000_0000, 32'h0000_0000});
        write_matrix(5, {32'h0000_0000, 32'h0001_0000});
        write_matrix(6, {32'h0000_0000, 32'h0000_0000});
        write_matrix(7, {32'h0001_0000, 32'h0000_0000});
        send_request(sbmr_pkg::KIND_CLEAR, 0, 0, 0, m);
        for (int i = 0; i < 66; i++) begin
            send_request(sbmr_pkg::KIND_ADD, 16'(i * 997), 16'h0400, 0, m);
        end
        send_request(sbmr_pkg::KIND_QUERY, 16'h0010, 16'h0400, 0, m);
        send_request(sbmr_pkg::KIND_QUERY, 16'hFFFF, 16'h03D1, 0, m);
        wait_drained();
        random_matrix(1);
        send_request(sbmr_pkg::KIND_QUERY, 16'hFFFF, 16'h0400, 0, m);
        send_request(sbmr_pkg::KIND_QUERY, 16'h0000, 16'h042F, 0, m);
        wait_drained();

        send_idle_pct = 30;
        recv_idle_pct = 73;
        random_matrix(0);
        run_frames(RANDOM_ITEMS / 3);
        wait_drained();

        send_idle_pct = 73;
        recv_idle_pct = 30;
        random_matrix(0);
        run_frames(RANDOM_ITEMS / 3);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_matrix(0);
        hold_off <= 3000;
        run_frames(RANDOM_ITEMS / 3);
        wait_drained();
        stimulus_done = 1;

        $display("covered %0d queries, %0d results checked, %0d with divide fault",
                 query_count, match_count, fault_count);
        $display("matrix settings: zero, identity, extremes and three random sets");
        if (mismatch_count == 0 && pending_matches.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

// ===== stereo_blob_match_reproject_top.f =====
+incdir+design
design/sbmr_pkg.sv
design/sbmr_in_if.sv
design/sbmr_out_if.sv
design/sbmr_store.sv
design/sbmr_mac.sv
design/sbmr_div.sv
design/stereo_blob_match_reproject_top.sv
sim/stereo_blob_match_reproject_top_tb.sv
